FILE: design/assert_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define WSDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define WSDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/wsdf_pkg.sv
// Types and constants of the WebSocket frame deframer.
`default_nettype none

package wsdf_pkg;

  typedef enum logic [1:0] {
    PH_HEAD    = 2'd0,
    PH_EXT     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_MSG_BYTE  = 3'd0,
    K_PING_BYTE = 3'd1,
    K_DONE      = 3'd2,
    K_TOO_LONG  = 3'd3,
    K_PONG      = 3'd4,
    K_CLOSE     = 3'd5,
    K_BAD_CTRL  = 3'd6,
    K_UNKNOWN   = 3'd7
  } kind_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN = 64'd125;
  localparam logic [15:0] LIMIT_RESET = 16'd4096;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: design/websocket_frame_deframer_core.sv
// WebSocket receive frame deframer: header decode, unmasking and result queue.
//
// Usage: feed the received connection stream one byte per word on the in_
// channel (in_valid/in_ready, in_rx_byte). Each byte is parsed in the cycle it
// is accepted; the results it causes (message bytes, ping bytes, message done,
// too long, pong request, close, bad control frame, unknown opcode) enter a
// four-entry result queue and leave on the out_ channel one word per cycle
// while out_ready is high, the last one of a byte marked by out_last_of_input.
// Each result is written into the registered queue and offered from there.
// The input takes one byte per cycle while each byte gives at most one result
// and the receiver takes every word; a byte that gives two results (last
// payload byte plus frame end) writes two words into the queue. in_ready is
// high while the queue has two free entries, so a stalled receiver backs up
// into the input once more than two words wait.
// cfg_valid/cfg_message_limit writes the message limit; cfg_ready is always
// high. Write it only while the block is idle.
// Reset (rst_n low at a clock edge) empties the queue, returns the parser to
// the start of a frame header and sets the message limit to 4096. After a
// close frame or a bad control frame the parser ignores all input until reset.
`default_nettype none

module websocket_frame_deframer_core #(
  parameter int MESSAGE_COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_message_limit,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [15:0]      out_message_length,
  output logic             out_last_of_input
);
  import wsdf_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = MESSAGE_COUNT_WIDTH;
  localparam int XW = (CW > 16) ? CW : 16;
  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  // parser state
  phase_t          phase_r, phase_nxt;
  logic [3:0]      hcnt_r, hcnt_nxt;
  logic [3:0]      need_r, need_nxt;
  logic [3:0]      ext_r, ext_nxt;
  logic            fin_r, fin_nxt;
  logic [3:0]      op_r, op_nxt;
  logic            mask_r, mask_nxt;
  logic [63:0]     len_r, len_nxt;
  logic [1:0]      off_r, off_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [15:0]     limit_r;

  // result queue
  result_t         fifo_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     cnt_r, cnt_nxt;

  logic            in_fire, pop;
  logic            hdr_done, frm_end;
  logic            a_vld, b_vld;
  result_t         a_res, b_res, r0, r1;
  logic [1:0]      n_wr;
  logic [XW-1:0]   lim_eff;
  logic [3:0]      need_v;
  logic [7:0]      pay_byte;
  logic            is_msg_op, is_ctrl_op;

  assign cfg_ready = 1'b1;
  assign in_ready  = (cnt_r <= (PW+1)'(DEPTH - 2));
  assign in_fire   = in_valid & in_ready;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;

  assign lim_eff = (XW'(limit_r) > XW'({CW{1'b1}})) ? XW'({CW{1'b1}}) : XW'(limit_r);
  assign pay_byte = in_rx_byte ^ (mask_r ? key_r[{~off_r, 3'b000} +: 8] : 8'h00);
  assign is_msg_op = (op_r == OP_TEXT) || (op_r == OP_CONT);
  assign is_ctrl_op = (op_r == OP_CLOSE) || (op_r == OP_PING) || (op_r == OP_PONG);

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    need_nxt  = need_r;
    ext_nxt   = ext_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    hdr_done  = 1'b0;
    frm_end   = 1'b0;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    a_res     = '0;
    b_res     = '0;
    need_v    = 4'd2;

    if (in_fire) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (hcnt_r == 4'd0) begin
            fin_nxt  = in_rx_byte[7];
            op_nxt   = in_rx_byte[3:0];
            hcnt_nxt = 4'd1;
          end else begin
            mask_nxt = in_rx_byte[7];
            if (in_rx_byte[6:0] == LEN_EXT16) begin
              ext_nxt = 4'd2;
            end else if (in_rx_byte[6:0] == LEN_EXT64) begin
              ext_nxt = 4'd8;
            end else begin
              ext_nxt = 4'd0;
            end
            need_v   = 4'd2 + ext_nxt + (in_rx_byte[7] ? 4'd4 : 4'd0);
            need_nxt = need_v;
            len_nxt  = (in_rx_byte[6:0] < LEN_EXT16) ? 64'(in_rx_byte[6:0]) : 64'd0;
            key_nxt  = '0;
            hcnt_nxt = 4'd2;
            if (need_v == 4'd2) begin
              hdr_done = 1'b1;
            end else begin
              phase_nxt = PH_EXT;
            end
          end
        end
        PH_EXT: begin
          // length bytes come first, then the masking key
          if (hcnt_r < 4'd2 + ext_r) begin
            len_nxt = {len_r[55:0], in_rx_byte};
          end else begin
            key_nxt = {key_r[23:0], in_rx_byte};
          end
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_r + 4'd1 >= need_r) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (is_msg_op) begin
            if (XW'(count_r) >= lim_eff) begin
              ovf_nxt = 1'b1;
            end else begin
              a_vld     = 1'b1;
              a_res     = '{kind: K_MSG_BYTE, data_byte: pay_byte,
                            message_length: 16'd0, last: 1'b0};
              count_nxt = count_r + CW'(1);
            end
          end else if (op_r == OP_PING) begin
            a_vld = 1'b1;
            a_res = '{kind: K_PING_BYTE, data_byte: pay_byte,
                      message_length: 16'd0, last: 1'b0};
          end
          off_nxt = off_r + 2'd1;
          // len_r counts the bytes still to come
          if (len_r <= 64'd1) begin
            frm_end = 1'b1;
          end else begin
            len_nxt = len_r - 64'd1;
          end
        end
        PH_HALT: begin
        end
      endcase
    end

    if (hdr_done) begin
      if (is_ctrl_op && ((len_nxt > CTRL_MAX_LEN) || !fin_r)) begin
        b_vld     = 1'b1;
        b_res     = '{kind: K_BAD_CTRL, data_byte: 8'd0, message_length: 16'd0, last: 1'b0};
        phase_nxt = PH_HALT;
      end else begin
        if (op_r == OP_TEXT) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        off_nxt   = 2'd0;
        hcnt_nxt  = 4'd0;
        need_nxt  = 4'd2;
        phase_nxt = PH_PAYLOAD;
        if (len_nxt == 64'd0) begin
          frm_end = 1'b1;
        end
      end
    end

    if (frm_end) begin
      phase_nxt = PH_HEAD;
      hcnt_nxt  = 4'd0;
      need_nxt  = 4'd2;
      len_nxt   = 64'd0;
      if (is_msg_op) begin
        if (fin_r) begin
          b_vld = 1'b1;
          if (ovf_nxt) begin
            b_res = '{kind: K_TOO_LONG, data_byte: 8'd0, message_length: 16'd0, last: 1'b0};
          end else begin
            b_res = '{kind: K_DONE, data_byte: 8'd0,
                      message_length: 16'(XW'(count_nxt)), last: 1'b0};
          end
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end else if (op_r == OP_CLOSE) begin
        b_vld     = 1'b1;
        b_res     = '{kind: K_CLOSE, data_byte: 8'd0, message_length: 16'd0, last: 1'b0};
        phase_nxt = PH_HALT;
      end else if (op_r == OP_PING) begin
        b_vld = 1'b1;
        b_res = '{kind: K_PONG, data_byte: 8'd0, message_length: 16'd0, last: 1'b0};
      end else if ((op_r == OP_PONG) || (op_r == OP_BIN)) begin
        b_vld = 1'b0;
      end else begin
        b_vld = 1'b1;
        b_res = '{kind: K_UNKNOWN, data_byte: 8'd0, message_length: 16'd0, last: 1'b0};
      end
    end

    // pack the words of this byte, mark the last one
    a_res.last = !b_vld;
    b_res.last = 1'b1;
    r0   = a_vld ? a_res : b_res;
    r1   = b_res;
    n_wr = {1'b0, a_vld} + {1'b0, b_vld};
  end

  assign cnt_nxt = cnt_r + (PW+1)'(n_wr) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD;
      hcnt_r   <= 4'd0;
      need_r   <= 4'd2;
      ext_r    <= 4'd0;
      fin_r    <= 1'b0;
      op_r     <= OP_CONT;
      mask_r   <= 1'b0;
      len_r    <= 64'd0;
      off_r    <= 2'd0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      limit_r  <= LIMIT_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      need_r   <= need_nxt;
      ext_r    <= ext_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      off_r    <= off_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_message_limit;
      end
      wr_ptr_r <= wr_ptr_r + PW'(n_wr);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (n_wr != 2'd0) begin
      fifo_r[wr_ptr_r] <= r0;
    end
    if (n_wr == 2'd2) begin
      fifo_r[wr_ptr_r + PW'(1)] <= r1;
    end
  end

  assign out_kind           = fifo_r[rd_ptr_r].kind;
  assign out_data_byte      = fifo_r[rd_ptr_r].data_byte;
  assign out_message_length = fifo_r[rd_ptr_r].message_length;
  assign out_last_of_input  = fifo_r[rd_ptr_r].last;

  `WSDF_ASSERT(a_fifo_bound, cnt_r <= (PW+1)'(DEPTH), "result queue count exceeds depth")
  `WSDF_ASSERT(a_halt_sticks, phase_r == PH_HALT |=> phase_r == PH_HALT, "parser left halt")
  `WSDF_ASSERT(a_halt_silent, (in_fire && phase_r == PH_HALT) |-> n_wr == 2'd0,
    "halted parser produced a word")
  `WSDF_ASSERT(a_ext_count, phase_r == PH_EXT |-> hcnt_r < need_r,
    "header count ran past header length")
  `WSDF_ASSERT(a_no_overrun, n_wr != 2'd0 |-> in_fire, "word written without input")

endmodule

`default_nettype wire
